/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fses_pkg.sv */
//------------------------------------------------------------------------------
// fses_pkg
// Shared types, codes and tables of the frame sequencer block.
//------------------------------------------------------------------------------
`default_nettype none

package fses_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] SEL_CONTROL = 3'd0;
    localparam logic [2:0] SEL_SWEEP   = 3'd1;
    localparam logic [2:0] SEL_PER_LO  = 3'd2;
    localparam logic [2:0] SEL_PER_HI  = 3'd3;
    localparam logic [2:0] SEL_ENABLE  = 3'd4;
    localparam logic [2:0] SEL_MODE    = 3'd5;

    localparam logic [19:0] ENV_MODULUS = 20'd720720;

    // Classified command handed from the front part to the back part.
    typedef enum logic [2:0] {
        K_NOP  = 3'd0,
        K_CTRL = 3'd1,
        K_SWP  = 3'd2,
        K_PLO  = 3'd3,
        K_PHI  = 3'd4,
        K_ENA  = 3'd5,
        K_MODE = 3'd6,
        K_TICK = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] chan;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0: v = 8'h0a;  5'd1: v = 8'hfe;  5'd2: v = 8'h14;  5'd3: v = 8'h02;
            5'd4: v = 8'h28;  5'd5: v = 8'h04;  5'd6: v = 8'h50;  5'd7: v = 8'h06;
            5'd8: v = 8'ha0;  5'd9: v = 8'h08;  5'd10: v = 8'h3c; 5'd11: v = 8'h0a;
            5'd12: v = 8'h0e; 5'd13: v = 8'h0c; 5'd14: v = 8'h1a; 5'd15: v = 8'h0e;
            5'd16: v = 8'h0c; 5'd17: v = 8'h10; 5'd18: v = 8'h18; 5'd19: v = 8'h12;
            5'd20: v = 8'h30; 5'd21: v = 8'h14; 5'd22: v = 8'h60; 5'd23: v = 8'h16;
            5'd24: v = 8'hc0; 5'd25: v = 8'h18; 5'd26: v = 8'h48; 5'd27: v = 8'h1a;
            5'd28: v = 8'h10; 5'd29: v = 8'h1c; 5'd30: v = 8'h20; 5'd31: v = 8'h1e;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/fses_front.sv */
//------------------------------------------------------------------------------
// fses_front
// Accepts items, classifies them into commands and queues them for the back.
//------------------------------------------------------------------------------
`default_nettype none

module fses_front
    import fses_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_opcode,
    input  wire logic [2:0] i_reg_select,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_write_data,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_take
);

    t_cmd r_queue [QUEUE_DEPTH];
    logic r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd n_cmd;
    logic push, pop;
    logic chan_ok;

    assign chan_ok = ({1'b0, i_channel} < 3'(NUM_CHANNELS));

    always_comb begin
        n_cmd.chan = i_channel;
        n_cmd.data = i_write_data;
        n_cmd.kind = K_NOP;
        if (i_opcode) begin
            n_cmd.kind = K_TICK;
        end else begin
            case (i_reg_select)
                SEL_CONTROL: n_cmd.kind = chan_ok ? K_CTRL : K_NOP;
                SEL_SWEEP:   n_cmd.kind = chan_ok ? K_SWP : K_NOP;
                SEL_PER_LO:  n_cmd.kind = chan_ok ? K_PLO : K_NOP;
                SEL_PER_HI:  n_cmd.kind = chan_ok ? K_PHI : K_NOP;
                SEL_ENABLE:  n_cmd.kind = K_ENA;
                SEL_MODE:    n_cmd.kind = K_MODE;
                default:     n_cmd.kind = K_NOP;
            endcase
        end
    end

    assign o_stall     = (r_fill == 2'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/fses_back.sv */
//------------------------------------------------------------------------------
// fses_back
// Executes queued commands one channel per cycle and holds the result item.
//------------------------------------------------------------------------------
`default_nettype none

module fses_back
    import fses_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_take,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_volume_a,
    output logic [3:0]       o_volume_b,
    output logic [3:0]       o_volume_c,
    output logic [11:0]      o_period_a,
    output logic [11:0]      o_period_b,
    output logic [11:0]      o_period_c,
    output logic [5:0]       o_duty_codes,
    output logic [2:0]       o_active_mask
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [CW-1:0] r_ch;
    logic   r_half, r_quarter;
    logic   r_mode;
    logic [2:0] r_step;

    logic [11:0] r_period  [NUM_CHANNELS];
    logic [7:0]  r_len     [NUM_CHANNELS];
    logic        r_cnt_on  [NUM_CHANNELS];
    logic        r_env_on  [NUM_CHANNELS];
    logic [3:0]  r_decay   [NUM_CHANNELS];
    logic [1:0]  r_duty    [NUM_CHANNELS];
    logic        r_swp_on  [NUM_CHANNELS];
    logic [2:0]  r_shift   [NUM_CHANNELS];
    logic        r_negate  [NUM_CHANNELS];
    logic [2:0]  r_rate    [NUM_CHANNELS];
    logic [7:0]  r_swp_cnt [NUM_CHANNELS];
    logic [3:0]  r_level   [NUM_CHANNELS];
    logic [19:0] r_env_cnt [NUM_CHANNELS];
    logic        r_enabled [NUM_CHANNELS];
    logic        r_expired [NUM_CHANNELS];

    // Per-channel divider remainders tracked alongside the counters so that
    // the modulo tests need only an increment and a compare.
    logic [2:0]  r_swp_rem [NUM_CHANNELS];
    logic [3:0]  r_env_rem [NUM_CHANNELS];

    // Remainder rebuild after a divisor change, four dividend bits per cycle.
    logic [19:0] r_div_num;
    logic [4:0]  r_div_den;
    logic [4:0]  r_div_rem;
    logic [2:0]  r_div_cnt;
    logic [4:0]  n_div_rem;
    logic [5:0]  d_trial;

    logic [3:0]  r_vol_o [3];
    logic [11:0] r_per_o [3];
    logic [5:0]  r_duty_o;
    logic [2:0]  r_act_o;

    logic [2:0] n_step;
    logic       last_ch;

    // Work on the selected channel during a tick.
    logic [7:0]  h_len;
    logic        h_cnt_on, h_expired, h_swp_hit, h_swp_go;
    logic [7:0]  h_swp_cnt;
    logic [2:0]  h_swp_rem;
    logic [12:0] h_sum;
    logic [11:0] h_delta, h_period;
    logic        h_cut;
    logic [19:0] q_env_cnt;
    logic [3:0]  q_env_rem, q_level;

    assign o_cmd_take = (r_state == ST_IDLE);
    assign last_ch    = (r_ch == CW'(NUM_CHANNELS - 1));

    always_comb begin
        if (r_mode) n_step = (r_step == 3'd4) ? 3'd0 : r_step + 3'd1;
        else        n_step = {1'b0, r_step[1:0] + 2'd1};
    end

    always_comb begin
        n_div_rem = r_div_rem;
        d_trial   = 6'd0;
        for (int k = 0; k < 4; k++) begin
            d_trial = {n_div_rem, r_div_num[19 - k]};
            if (d_trial >= {1'b0, r_div_den}) d_trial = d_trial - {1'b0, r_div_den};
            n_div_rem = d_trial[4:0];
        end
    end

    always_comb begin
        h_len     = r_len[r_ch];
        h_cnt_on  = r_cnt_on[r_ch];
        h_expired = r_expired[r_ch];
        if (r_cnt_on[r_ch]) begin
            h_len = r_len[r_ch] - 8'd1;
            if (h_len == 8'd0) begin
                h_cnt_on  = 1'b0;
                h_expired = 1'b1;
            end
        end
        h_swp_go  = r_swp_on[r_ch] && (h_len != 8'd0) && (r_shift[r_ch] != 3'd0);
        h_swp_cnt = r_swp_cnt[r_ch] + 8'd1;
        // The count wraps modulo 256, so the remainder restarts at zero too.
        if (h_swp_cnt == 8'd0) h_swp_rem = 3'd0;
        else if (r_swp_rem[r_ch] == r_rate[r_ch]) h_swp_rem = 3'd0;
        else h_swp_rem = r_swp_rem[r_ch] + 3'd1;
        h_swp_hit = h_swp_go && (h_swp_rem == 3'd0);
        h_delta   = r_period[r_ch] >> r_shift[r_ch];
        if (r_negate[r_ch]) h_sum = {1'b0, r_period[r_ch]} - {1'b0, h_delta};
        else                h_sum = {1'b0, r_period[r_ch]} + {1'b0, h_delta};
        h_period = r_period[r_ch];
        if (h_swp_hit) h_period = h_sum[12] ? 12'hfff : h_sum[11:0];
        h_cut = (h_period > 12'h7ff) || (h_period < 12'd8);

        q_env_cnt = (r_env_cnt[r_ch] == ENV_MODULUS - 20'd1) ? 20'd0
                                                              : r_env_cnt[r_ch] + 20'd1;
        if (q_env_cnt == 20'd0) q_env_rem = 4'd0;
        else if (r_env_rem[r_ch] == r_decay[r_ch]) q_env_rem = 4'd0;
        else q_env_rem = r_env_rem[r_ch] + 4'd1;
        q_level = r_level[r_ch];
        if (q_env_rem == 4'd0) begin
            // The envelope sees the length flag after this tick's half-frame work.
            if (r_level[r_ch] == 4'd0 && (r_half ? h_cnt_on : r_cnt_on[r_ch]))
                q_level = 4'hf;
            else if (r_level[r_ch] != 4'd0) q_level = r_level[r_ch] - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= 1'b0;
            r_step  <= 3'd0;
            r_ch    <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_period[c] <= '0;  r_len[c] <= '0;     r_cnt_on[c] <= 1'b0;
                r_env_on[c] <= 1'b0; r_decay[c] <= '0;  r_duty[c] <= '0;
                r_swp_on[c] <= 1'b0; r_shift[c] <= '0;  r_negate[c] <= 1'b0;
                r_rate[c] <= '0;    r_swp_cnt[c] <= '0; r_level[c] <= '0;
                r_env_cnt[c] <= '0; r_enabled[c] <= 1'b0; r_expired[c] <= 1'b0;
                r_swp_rem[c] <= '0; r_env_rem[c] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_ch    <= '0;
                        r_state <= ST_RUN;
                        if (i_cmd.kind == K_TICK) begin
                            r_step    <= n_step;
                            r_half    <= n_step[0];
                            r_quarter <= !(r_mode && n_step == 3'd4);
                        end else begin
                            r_half    <= 1'b0;
                            r_quarter <= 1'b0;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_cmd.kind == K_TICK) begin
                        if (r_half) begin
                            r_len[r_ch]    <= h_len;
                            r_cnt_on[r_ch] <= h_cnt_on;
                            r_expired[r_ch] <= h_expired;
                            if (h_swp_go) begin
                                r_swp_cnt[r_ch] <= h_swp_cnt;
                                r_swp_rem[r_ch] <= h_swp_rem;
                            end
                            r_period[r_ch] <= h_period;
                            if (h_cut) begin
                                r_swp_on[r_ch]  <= 1'b0;
                                r_enabled[r_ch] <= 1'b0;
                            end
                        end
                        if (r_quarter && r_env_on[r_ch]) begin
                            r_env_cnt[r_ch] <= q_env_cnt;
                            r_env_rem[r_ch] <= q_env_rem;
                            r_level[r_ch]   <= q_level;
                        end
                        if (last_ch) r_state <= ST_OUT;
                        else r_ch <= r_ch + CW'(1);
                    end else begin
                        case (r_cmd.kind)
                            K_CTRL: begin
                                r_decay[r_cmd.chan[CW-1:0]]  <= r_cmd.data[3:0];
                                r_env_on[r_cmd.chan[CW-1:0]] <= !r_cmd.data[4];
                                r_cnt_on[r_cmd.chan[CW-1:0]] <= !r_cmd.data[5];
                                r_duty[r_cmd.chan[CW-1:0]]   <= r_cmd.data[7:6];
                                // A new divisor restarts the remainder from the count.
                                r_div_num <= r_env_cnt[r_cmd.chan[CW-1:0]];
                                r_div_den <= {1'b0, r_cmd.data[3:0]} + 5'd1;
                                r_div_rem <= 5'd0;
                                r_div_cnt <= 3'd5;
                            end
                            K_SWP: begin
                                r_shift[r_cmd.chan[CW-1:0]]  <= r_cmd.data[2:0];
                                r_negate[r_cmd.chan[CW-1:0]] <= r_cmd.data[3];
                                r_rate[r_cmd.chan[CW-1:0]]   <= r_cmd.data[6:4];
                                r_swp_on[r_cmd.chan[CW-1:0]] <= r_cmd.data[7];
                                r_div_num <= {r_swp_cnt[r_cmd.chan[CW-1:0]], 12'd0};
                                r_div_den <= {2'b0, r_cmd.data[6:4]} + 5'd1;
                                r_div_rem <= 5'd0;
                                r_div_cnt <= 3'd2;
                            end
                            K_PLO: r_period[r_cmd.chan[CW-1:0]][7:0] <= r_cmd.data;
                            K_PHI: begin
                                r_period[r_cmd.chan[CW-1:0]][11:8] <= {1'b0, r_cmd.data[2:0]};
                                r_len[r_cmd.chan[CW-1:0]]     <= len_lookup(r_cmd.data[7:3]);
                                r_level[r_cmd.chan[CW-1:0]]   <= 4'hf;
                                r_env_cnt[r_cmd.chan[CW-1:0]] <= '0;
                                r_env_rem[r_cmd.chan[CW-1:0]] <= '0;
                                r_swp_cnt[r_cmd.chan[CW-1:0]] <= '0;
                                r_swp_rem[r_cmd.chan[CW-1:0]] <= '0;
                                r_expired[r_cmd.chan[CW-1:0]] <= 1'b0;
                            end
                            K_ENA: begin
                                for (int c = 0; c < NUM_CHANNELS; c++)
                                    r_enabled[c] <= r_cmd.data[c];
                            end
                            K_MODE: r_mode <= r_cmd.data[7];
                            default: ;
                        endcase
                        if (r_cmd.kind == K_CTRL || r_cmd.kind == K_SWP) r_state <= ST_DIV;
                        else r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    r_div_rem <= n_div_rem;
                    r_div_num <= {r_div_num[15:0], 4'd0};
                    r_div_cnt <= r_div_cnt - 3'd1;
                    if (r_div_cnt == 3'd1) begin
                        if (r_cmd.kind == K_CTRL)
                            r_env_rem[r_cmd.chan[CW-1:0]] <= n_div_rem[3:0];
                        else
                            r_swp_rem[r_cmd.chan[CW-1:0]] <= n_div_rem[2:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_vol_o[c] = 4'd0;
            r_per_o[c] = 12'd0;
        end
        r_duty_o = 6'd0;
        r_act_o  = 3'd0;
        for (int c = 0; c < NUM_CHANNELS && c < 3; c++) begin
            r_vol_o[c] = r_env_on[c] ? r_level[c] : r_decay[c];
            r_per_o[c] = r_period[c];
            r_duty_o[2*c +: 2] = r_duty[c];
            r_act_o[c] = r_enabled[c] && !r_expired[c];
        end
    end

    assign o_valid       = (r_state == ST_OUT);
    assign o_volume_a    = r_vol_o[0];
    assign o_volume_b    = r_vol_o[1];
    assign o_volume_c    = r_vol_o[2];
    assign o_period_a    = r_per_o[0];
    assign o_period_b    = r_per_o[1];
    assign o_period_c    = r_per_o[2];
    assign o_duty_codes  = r_duty_o;
    assign o_active_mask = r_act_o;

endmodule

`default_nettype wire

/* rtl/frame_sequencer_envelope_sweep.sv */
//------------------------------------------------------------------------------
// frame_sequencer_envelope_sweep
// Length counters, period sweep and envelopes of a three-channel sound unit.
//------------------------------------------------------------------------------
// Channel  Direction  Handshake            Content
// in       input      i_valid / o_stall    opcode, reg_select, channel, write_data
// out      output     o_valid / i_stall    volumes, periods, duty codes, active mask
//
// A write passes the queue, then the run and output states of the back part; a control
// or sweep write also passes the divide state, which rebuilds the divider remainder
// four bits per cycle. In a tick the back part walks the channels one per cycle.
// The two-entry command queue lets the input run ahead while a result waits.
// Reset is synchronous and clears all channel state; no clearing pass is needed.
//------------------------------------------------------------------------------
`default_nettype none

module frame_sequencer_envelope_sweep
    import fses_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [2:0]  i_reg_select,
    input  wire logic [1:0]  i_channel,
    input  wire logic [7:0]  i_write_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_volume_a,
    output logic [3:0]       o_volume_b,
    output logic [3:0]       o_volume_c,
    output logic [11:0]      o_period_a,
    output logic [11:0]      o_period_b,
    output logic [11:0]      o_period_c,
    output logic [5:0]       o_duty_codes,
    output logic [2:0]       o_active_mask
);

    logic cmd_valid, cmd_take;
    t_cmd cmd;

    fses_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_opcode, .i_reg_select, .i_channel, .i_write_data,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    fses_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_valid, .i_stall,
        .o_volume_a, .o_volume_b, .o_volume_c,
        .o_period_a, .o_period_b, .o_period_c,
        .o_duty_codes, .o_active_mask
    );

endmodule

`default_nettype wire

/* rtl/fses_checker.sv */
//------------------------------------------------------------------------------
// fses_checker
// Port-level checks of the frame sequencer block, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fses_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_stall,
    input wire logic [11:0] o_period_a,
    input wire logic [2:0]  o_active_mask
);

    // A waiting result must stay valid with its channel A period held.
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_period_a), "result changed while stalled")
    // A result is never shown twice back to back.
    `CHK_NEXT(a_no_dup, i_clk, i_rst_n, o_valid && !i_stall, !o_valid, "result repeated")
    // Just after reset the block is ready and shows nothing.
    `CHK_NEXT(a_reset, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall, "bad reset state")
    // The active mask holds with the rest of a stalled result.
    `CHK_NEXT(a_mask, i_clk, i_rst_n, o_valid && i_stall, $stable(o_active_mask), "mask changed while stalled")

endmodule

bind frame_sequencer_envelope_sweep fses_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_stall, .o_period_a, .o_active_mask
);

`default_nettype wire

/* tb/sv/frame_sequencer_envelope_sweep_test.sv */
//------------------------------------------------------------------------------
// frame_sequencer_envelope_sweep_test
// Drives register writes and frame ticks into the sound-unit control block,
// tracks the channel state alongside it and checks every reported snapshot.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_sequencer_envelope_sweep_test;
    import fses_pkg::*;

    localparam int NCH = 3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [3:0]  vol_a;
        logic [3:0]  vol_b;
        logic [3:0]  vol_c;
        logic [11:0] per_a;
        logic [11:0] per_b;
        logic [11:0] per_c;
        logic [5:0]  duty;
        logic [2:0]  act;
    } t_snapshot;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic [2:0]  i_reg_select;
    logic [1:0]  i_channel;
    logic [7:0]  i_write_data;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_volume_a, o_volume_b, o_volume_c;
    logic [11:0] o_period_a, o_period_b, o_period_c;
    logic [5:0]  o_duty_codes;
    logic [2:0]  o_active_mask;

    frame_sequencer_envelope_sweep u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_reg_select(i_reg_select), .i_channel(i_channel),
        .i_write_data(i_write_data), .o_valid(o_valid), .i_stall(i_stall),
        .o_volume_a(o_volume_a), .o_volume_b(o_volume_b), .o_volume_c(o_volume_c),
        .o_period_a(o_period_a), .o_period_b(o_period_b), .o_period_c(o_period_c),
        .o_duty_codes(o_duty_codes), .o_active_mask(o_active_mask)
    );

    // Mirrored channel state.
    logic        m_mode;
    logic [2:0]  m_step;
    logic [11:0] m_period [NCH];
    logic [7:0]  m_length [NCH];
    logic        m_count_on [NCH];
    logic        m_env_on [NCH];
    logic [3:0]  m_decay [NCH];
    logic [1:0]  m_duty [NCH];
    logic        m_sw_on [NCH];
    logic [2:0]  m_sw_shift [NCH];
    logic        m_sw_neg [NCH];
    logic [2:0]  m_sw_rate [NCH];
    logic [7:0]  m_sw_count [NCH];
    logic [3:0]  m_env_level [NCH];
    logic [19:0] m_env_count [NCH];
    logic        m_enabled [NCH];
    logic        m_expired [NCH];

    t_snapshot expected_snapshots[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  ticks_sent = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] length_entry(input logic [4:0] idx);
        logic [7:0] tbl [32];
        tbl = '{8'h0a, 8'hfe, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
                8'ha0, 8'h08, 8'h3c, 8'h0a, 8'h0e, 8'h0c, 8'h1a, 8'h0e,
                8'h0c, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
                8'hc0, 8'h18, 8'h48, 8'h1a, 8'h10, 8'h1c, 8'h20, 8'h1e};
        return tbl[idx];
    endfunction

    task automatic clear_mirror();
        m_mode = 1'b0;
        m_step = '0;
        for (int c = 0; c < NCH; c++) begin
            m_period[c] = '0; m_length[c] = '0; m_count_on[c] = 0; m_env_on[c] = 0;
            m_decay[c] = '0; m_duty[c] = '0; m_sw_on[c] = 0; m_sw_shift[c] = '0;
            m_sw_neg[c] = 0; m_sw_rate[c] = '0; m_sw_count[c] = '0;
            m_env_level[c] = '0; m_env_count[c] = '0; m_enabled[c] = 0;
            m_expired[c] = 0;
        end
    endtask

    function automatic void clock_half_frame();
        logic [12:0] p;
        logic [11:0] delta;
        for (int c = 0; c < NCH; c++) begin
            if (m_count_on[c]) begin
                m_length[c] = m_length[c] - 8'd1;
                if (m_length[c] == 0) begin
                    m_count_on[c] = 0;
                    m_expired[c] = 1;
                end
            end
            if (m_sw_on[c] && m_length[c] != 0 && m_sw_shift[c] != 0) begin
                m_sw_count[c] = m_sw_count[c] + 8'd1;
                if ((m_sw_count[c] % ({5'd0, m_sw_rate[c]} + 8'd1)) == 0) begin
                    delta = m_period[c] >> m_sw_shift[c];
                    if (m_sw_neg[c])
                        p = {1'b0, m_period[c]} - {1'b0, delta};
                    else
                        p = {1'b0, m_period[c]} + {1'b0, delta};
                    m_period[c] = (p > 13'hfff) ? 12'hfff : p[11:0];
                end
            end
            if (m_period[c] > 12'h7ff || m_period[c] < 12'd8) begin
                m_sw_on[c] = 0;
                m_enabled[c] = 0;
            end
        end
    endfunction

    function automatic void clock_envelopes();
        for (int c = 0; c < NCH; c++) begin
            if (m_env_on[c]) begin
                m_env_count[c] = (m_env_count[c] + 20'd1) % ENV_MODULUS;
                if (m_env_count[c] % ({16'd0, m_decay[c]} + 20'd1) == 0) begin
                    if (m_env_level[c] == 0 && m_count_on[c])
                        m_env_level[c] = 4'd15;
                    else if (m_env_level[c] > 0)
                        m_env_level[c] = m_env_level[c] - 4'd1;
                end
            end
        end
    endfunction

    function automatic void apply_register_write(input logic [2:0] sel,
                                                 input logic [1:0] ch,
                                                 input logic [7:0] d);
        if (sel == SEL_ENABLE) begin
            for (int c = 0; c < NCH; c++) m_enabled[c] = d[c];
        end else if (sel == SEL_MODE) begin
            m_mode = d[7];
        end else if (sel <= SEL_PER_HI && ch < NCH) begin
            case (sel)
                SEL_CONTROL: begin
                    m_decay[ch] = d[3:0];
                    m_env_on[ch] = !d[4];
                    m_count_on[ch] = !d[5];
                    m_duty[ch] = d[7:6];
                end
                SEL_SWEEP: begin
                    m_sw_shift[ch] = d[2:0];
                    m_sw_neg[ch] = d[3];
                    m_sw_rate[ch] = d[6:4];
                    m_sw_on[ch] = d[7];
                end
                SEL_PER_LO: m_period[ch][7:0] = d;
                default: begin
                    m_period[ch] = {1'b0, d[2:0], m_period[ch][7:0]};
                    m_length[ch] = length_entry(d[7:3]);
                    m_env_level[ch] = 4'd15;
                    m_env_count[ch] = '0;
                    m_sw_count[ch] = '0;
                    m_expired[ch] = 0;
                end
            endcase
        end
    endfunction

    // Updates the mirror for one item and returns the snapshot it must produce.
    function automatic t_snapshot predict_snapshot(input logic op, input logic [2:0] sel,
                                                   input logic [1:0] ch,
                                                   input logic [7:0] d);
        t_snapshot s;
        logic [3:0] vol [NCH];
        if (op == OP_TICK) begin
            if (m_mode == 1'b0) m_step = (m_step + 3'd1) % 3'd4;
            else m_step = (m_step == 3'd4) ? 3'd0 : m_step + 3'd1;
            if (m_step[0]) clock_half_frame();
            if (!(m_mode && m_step == 3'd4)) clock_envelopes();
        end else begin
            apply_register_write(sel, ch, d);
        end
        for (int c = 0; c < NCH; c++)
            vol[c] = m_env_on[c] ? m_env_level[c] : m_decay[c];
        s.vol_a = vol[0]; s.vol_b = vol[1]; s.vol_c = vol[2];
        s.per_a = m_period[0]; s.per_b = m_period[1]; s.per_c = m_period[2];
        s.duty = {m_duty[2], m_duty[1], m_duty[0]};
        for (int c = 0; c < NCH; c++) s.act[c] = m_enabled[c] && !m_expired[c];
        return s;
    endfunction

    // Sends one item and holds it until the block takes it.
    task automatic send_item(input logic op, input logic [2:0] sel, input logic [1:0] ch,
                             input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode <= op;
        i_reg_select <= sel;
        i_channel <= ch;
        i_write_data <= d;
        do @(posedge i_clk); while (o_stall);
        expected_snapshots.push_back(predict_snapshot(op, sel, ch, d));
        items_sent++;
        if (op == OP_TICK) ticks_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 3'($urandom_range(7)), 2'($urandom_range(3)),
                  8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        while (expected_snapshots.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_snapshot got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_volume_a, o_volume_b, o_volume_c, o_period_a, o_period_b,
                    o_period_c, o_duty_codes, o_active_mask};
            results_seen++;
            if (expected_snapshots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_snapshots.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected %h got %h",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL frame_sequencer_envelope_sweep");
            $finish;
        end
    end

    task automatic test_register_writes();
        for (int c = 0; c < 4; c++) begin
            send_item(OP_WRITE, SEL_CONTROL, 2'(c), 8'hff);
            send_item(OP_WRITE, SEL_CONTROL, 2'(c), 8'h00);
            send_item(OP_WRITE, SEL_SWEEP, 2'(c), 8'hff);
            send_item(OP_WRITE, SEL_PER_LO, 2'(c), 8'hff);
            send_item(OP_WRITE, SEL_PER_HI, 2'(c), 8'hff);
        end
        send_item(OP_WRITE, SEL_ENABLE, 2'd3, 8'hff);
        send_item(OP_WRITE, 3'd6, 2'd0, 8'h55);
        send_item(OP_WRITE, 3'd7, 2'd1, 8'haa);
        send_item(OP_WRITE, SEL_MODE, 2'd0, 8'h80);
        for (int i = 0; i < 6; i++) send_tick();
        send_item(OP_WRITE, SEL_MODE, 2'd2, 8'h7f);
    endtask

    // A short length counter expires; sweep pushes periods into cutoff.
    task automatic test_sweep_and_length();
        for (int c = 0; c < NCH; c++) begin
            send_item(OP_WRITE, SEL_CONTROL, 2'(c), 8'h01);
            send_item(OP_WRITE, SEL_SWEEP, 2'(c), (c == 1) ? 8'h89 : 8'h81);
            send_item(OP_WRITE, SEL_PER_LO, 2'(c), 8'h00);
            send_item(OP_WRITE, SEL_PER_HI, 2'(c), (c == 2) ? 8'h1f : 8'h0f);
        end
        send_item(OP_WRITE, SEL_ENABLE, 2'd0, 8'h07);
        for (int i = 0; i < 40; i++) send_tick();
    endtask

    task automatic test_random_sequences(input int count);
        int n;
        logic [1:0] ch;
        n = 0;
        while (n < count) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    // Full channel setup followed by an enable write.
                    ch = 2'($urandom_range(2));
                    send_item(OP_WRITE, SEL_CONTROL, ch, 8'($urandom));
                    send_item(OP_WRITE, SEL_SWEEP, ch, 8'($urandom));
                    send_item(OP_WRITE, SEL_PER_LO, ch, 8'($urandom));
                    send_item(OP_WRITE, SEL_PER_HI, ch, 8'($urandom));
                    send_item(OP_WRITE, SEL_ENABLE, 2'($urandom), 8'($urandom));
                    n += 5;
                end
                3: begin
                    send_item(OP_WRITE, SEL_MODE, 2'($urandom), 8'($urandom));
                    n++;
                end
                4: begin
                    send_item(OP_WRITE, 3'($urandom), 2'($urandom), 8'($urandom));
                    n++;
                end
                default: begin
                    for (int i = $urandom_range(1, 8); i > 0; i--) begin
                        send_tick();
                        n++;
                    end
                end
            endcase
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_opcode = OP_WRITE;
        i_reg_select = '0;
        i_channel = '0;
        i_write_data = '0;
        clear_mirror();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_writes();
        test_sweep_and_length();
        wait_drained();
        send_idle_pct = 17; recv_idle_pct = 55;
        test_random_sequences(620);
        send_idle_pct = 55; recv_idle_pct = 17;
        test_random_sequences(620);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_sequences(620);
        repeat (20) @(negedge i_clk);

        $display("Covered %0d items (%0d frame ticks) with %0d results checked.",
                 items_sent, ticks_sent, results_seen);
        $display("Both sequencer modes, sweep cutoff, length expiry and envelopes ran.");
        if (mismatches == 0 && expected_snapshots.size() == 0)
            $display("PASS frame_sequencer_envelope_sweep");
        else
            $display("FAIL frame_sequencer_envelope_sweep");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/fses_pkg.sv
rtl/fses_front.sv
rtl/fses_back.sv
rtl/frame_sequencer_envelope_sweep.sv
rtl/fses_checker.sv
tb/sv/frame_sequencer_envelope_sweep_test.sv
